// ===== hw/rtl/arpc_pkg.sv =====
// arpc_pkg: shared types and constants for the arp cache table
// used by arpc_eval and arp_cache_table_with_ageing_unit
// no dependencies
`default_nettype none

package arpc_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;
  localparam int CFG_W = 8;
  localparam int CNT_W = 7;

  localparam logic [CNT_W-1:0] COUNT_MAX     = 7'd127;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 8'd15;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // per-entry verdict from the shared evaluation unit
  typedef struct packed {
    logic match;
    logic free;
    logic expire;
  } eval_t;

endpackage

`default_nettype wire

// ===== hw/rtl/arpc_ram.sv =====
// arpc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/arpc_eval.sv =====
// arpc_eval: shared per-entry unit, ip compare and age compare for one table word
// depends on arpc_pkg
`default_nettype none

module arpc_eval #(
  parameter int TIME_BITS = 16
) (
  input  wire logic                         entry_valid,
  input  wire logic [arpc_pkg::IP_W-1:0]    entry_ip,
  input  wire logic [TIME_BITS-1:0]         entry_stamp,
  input  wire logic [arpc_pkg::IP_W-1:0]    key_ip,
  input  wire logic [TIME_BITS-1:0]         now,
  input  wire logic [arpc_pkg::CFG_W-1:0]   timeout,
  output arpc_pkg::eval_t                   res
);

  logic [TIME_BITS-1:0] age;

  // age wraps with the time counter
  assign age = now - entry_stamp;

  always_comb begin
    res.match  = entry_valid && (entry_ip == key_ip);
    res.free   = !entry_valid;
    res.expire = entry_valid && (age > TIME_BITS'(timeout));
  end

endmodule

`default_nettype wire

// ===== hw/rtl/arp_cache_table_with_ageing_unit.sv =====
// arp_cache_table_with_ageing_unit: ip to mac cache with lookup, insert and ageing tick
// depends on arpc_pkg, arpc_ram, arpc_eval
// out_valid strobes in the finish state, after the scan and drain states; busy meanwhile
// one command at a time: start is taken only in idle, after the one-entry-per-cycle ram scan
// reset: after rst_n a clearing pass writes every slot invalid, busy high
// results cannot be stalled: each beat is on out_* for exactly one cycle with out_valid
`default_nettype none

module arp_cache_table_with_ageing_unit #(
  parameter int ENTRIES   = 64,
  parameter int TIME_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [arpc_pkg::CFG_W-1:0]    cfg_wr_data,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_command,
  input  wire logic [arpc_pkg::IP_W-1:0]     in_ip_addr,
  input  wire logic [arpc_pkg::MAC_W-1:0]    in_mac_addr,
  // result channel
  output logic                               out_valid,
  output logic                               out_hit,
  output logic      [arpc_pkg::MAC_W-1:0]    out_found_mac,
  output logic                               out_stored,
  output logic      [arpc_pkg::CNT_W-1:0]    out_expired_count
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int WORD_W = 1 + arpc_pkg::IP_W + arpc_pkg::MAC_W + TIME_BITS;
  // table word layout: {valid, ip, mac, stamp}
  localparam int STAMP_LO = 0;
  localparam int MAC_LO   = TIME_BITS;
  localparam int IP_LO    = TIME_BITS + arpc_pkg::MAC_W;
  localparam int VALID_B  = WORD_W - 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  arpc_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_last;

  // read pipeline: data in the ram output belongs to rd_idx_r
  logic             rd_pend_r;
  logic [IDX_W-1:0] rd_idx_r;

  logic [TIME_BITS-1:0]        now_r;
  logic [arpc_pkg::CFG_W-1:0]  timeout_r;

  // captured command beat
  arpc_pkg::cmd_t              cmd_r;
  logic [arpc_pkg::IP_W-1:0]   key_ip_r;
  logic [arpc_pkg::MAC_W-1:0]  key_mac_r;

  // scan accumulators
  logic                        hit_r;
  logic [arpc_pkg::MAC_W-1:0]  mac_r;
  logic                        found_r;
  logic [IDX_W-1:0]            ins_idx_r;
  logic [arpc_pkg::CNT_W-1:0]  exp_cnt_r;

  logic                        accept;

  // ram ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [WORD_W-1:0] ram_rdata;

  arpc_pkg::eval_t ev;

  assign accept   = start && !busy;
  assign cnt_last = (cnt_r == LAST_IDX);

  // ---------------------------------------------------------------- table storage
  arpc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (cnt_r),
    .rd_data (ram_rdata)
  );

  // ---------------------------------------------------------------- shared compare unit
  arpc_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .entry_valid (ram_rdata[VALID_B]),
    .entry_ip    (ram_rdata[IP_LO +: arpc_pkg::IP_W]),
    .entry_stamp (ram_rdata[STAMP_LO +: TIME_BITS]),
    .key_ip      (key_ip_r),
    .now         (now_r),
    .timeout     (timeout_r),
    .res         (ev)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      arpc_pkg::ST_CLEAR:  if (cnt_last) state_nxt = arpc_pkg::ST_IDLE;
      arpc_pkg::ST_IDLE:   if (start) state_nxt = arpc_pkg::ST_SCAN;
      arpc_pkg::ST_SCAN:   if (cnt_last) state_nxt = arpc_pkg::ST_DRAIN;
      arpc_pkg::ST_DRAIN:  state_nxt = arpc_pkg::ST_FINISH;
      arpc_pkg::ST_FINISH: state_nxt = arpc_pkg::ST_IDLE;
      default:             state_nxt = arpc_pkg::ST_IDLE;
    endcase
  end

  // scan counter walks the table once per command, and once for the clearing pass
  always_comb begin
    cnt_nxt = '0;
    unique case (state_r)
      arpc_pkg::ST_CLEAR,
      arpc_pkg::ST_SCAN: cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
      default:           cnt_nxt = '0;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    ram_re    = 1'b0;
    unique case (state_r)
      arpc_pkg::ST_IDLE:   busy = 1'b0;
      arpc_pkg::ST_SCAN:   ram_re = 1'b1;
      arpc_pkg::ST_FINISH: out_valid = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

  // write port: clearing pass, expiry write-back during a tick, or the insert at the end
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx_r;
    ram_wdata = {1'b0, ram_rdata[WORD_W-2:0]};
    if (state_r == arpc_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r;
      ram_wdata = '0;
    end else if (rd_pend_r && cmd_r == arpc_pkg::CMD_TICK && ev.expire) begin
      ram_we    = 1'b1;
    end else if (state_r == arpc_pkg::ST_FINISH && cmd_r == arpc_pkg::CMD_INSERT
                 && found_r) begin
      ram_we    = 1'b1;
      ram_waddr = ins_idx_r;
      ram_wdata = {1'b1, key_ip_r, key_mac_r, now_r};
    end
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= arpc_pkg::ST_CLEAR;
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
      now_r     <= '0;
      timeout_r <= arpc_pkg::TIMEOUT_RESET;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= (state_r == arpc_pkg::ST_SCAN);
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      // tick advances time before the ageing scan
      if (accept && in_command == arpc_pkg::CMD_TICK) begin
        now_r <= now_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    if (accept) begin
      cmd_r     <= arpc_pkg::cmd_t'(in_command);
      key_ip_r  <= in_ip_addr;
      key_mac_r <= in_mac_addr;
      hit_r     <= 1'b0;
      mac_r     <= '0;
      found_r   <= 1'b0;
      ins_idx_r <= '0;
      exp_cnt_r <= '0;
    end else if (rd_pend_r) begin
      case (cmd_r)
        arpc_pkg::CMD_LOOKUP: begin
          // later slots override earlier ones
          if (ev.match) begin
            hit_r <= 1'b1;
            mac_r <= ram_rdata[MAC_LO +: arpc_pkg::MAC_W];
          end
        end
        arpc_pkg::CMD_INSERT: begin
          // first free slot wins
          if (ev.free && !found_r) begin
            found_r   <= 1'b1;
            ins_idx_r <= rd_idx_r;
          end
        end
        arpc_pkg::CMD_TICK: begin
          if (ev.expire && exp_cnt_r != arpc_pkg::COUNT_MAX) begin
            exp_cnt_r <= exp_cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_hit           = hit_r;
  assign out_found_mac     = mac_r;
  assign out_stored        = found_r;
  assign out_expired_count = exp_cnt_r;

  // ---------------------------------------------------------------- assertions
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat outside a command");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid)
    else $error("command did not occupy the unit");

  a_miss_zero_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_found_mac == '0))
    else $error("mac reported without a hit");

  a_stored_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stored) |-> (cmd_r == arpc_pkg::CMD_INSERT))
    else $error("store flag on a non-insert command");

  a_scan_write_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r == arpc_pkg::ST_SCAN || state_r == arpc_pkg::ST_DRAIN))
      |-> (cmd_r == arpc_pkg::CMD_TICK))
    else $error("table written during a non-tick scan");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for arp_cache_table_with_ageing_unit, lookup, insert and tick beats
// depends on arpc_pkg and the unit; its predictor keeps its own copy of the table and clock

module tb;

  localparam int ENTRIES      = 64;
  localparam int TIME_BITS    = 16;
  localparam int RAND_ITEMS   = 950;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = ENTRIES + 8;
  localparam int NUM_DIR      = 26;
  localparam int POOL_SIZE    = 8;

  typedef struct packed {
    logic                       hit;
    logic [arpc_pkg::MAC_W-1:0] found_mac;
    logic                       stored;
    logic [arpc_pkg::CNT_W-1:0] expired_count;
  } reply_t;

  // one row of the directed table: either a timeout write or a command beat
  typedef struct packed {
    logic                       is_cfg;
    logic [arpc_pkg::CFG_W-1:0] cfg_val;
    arpc_pkg::cmd_t             cmd;
    logic [arpc_pkg::IP_W-1:0]  ip;
    logic [arpc_pkg::MAC_W-1:0] mac;
    logic                       typed;
    reply_t                     want;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [arpc_pkg::CFG_W-1:0] cfg_wr_data = '0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 in_command = arpc_pkg::CMD_LOOKUP;
  logic [arpc_pkg::IP_W-1:0]  in_ip_addr = '0;
  logic [arpc_pkg::MAC_W-1:0] in_mac_addr = '0;
  logic                       out_valid;
  logic                       out_hit;
  logic [arpc_pkg::MAC_W-1:0] out_found_mac;
  logic                       out_stored;
  logic [arpc_pkg::CNT_W-1:0] out_expired_count;

  arp_cache_table_with_ageing_unit #(
    .ENTRIES  (ENTRIES),
    .TIME_BITS(TIME_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_ip_addr       (in_ip_addr),
    .in_mac_addr      (in_mac_addr),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_found_mac    (out_found_mac),
    .out_stored       (out_stored),
    .out_expired_count(out_expired_count)
  );

  // shadow of the cache
  logic                       slot_valid [ENTRIES];
  logic [arpc_pkg::IP_W-1:0]  slot_ip    [ENTRIES];
  logic [arpc_pkg::MAC_W-1:0] slot_mac   [ENTRIES];
  logic [TIME_BITS-1:0]       slot_stamp [ENTRIES];
  logic [TIME_BITS-1:0]       now_q;
  logic [arpc_pkg::CFG_W-1:0] timeout_q;

  reply_t pending_replies [$];
  int     mismatches = 0;
  int     burst_left = 0;
  logic   cur_typed = 1'b0;
  reply_t cur_want = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  // applies one command to the shadow and returns the reply it should produce
  function automatic reply_t predict_reply(input arpc_pkg::cmd_t c,
                                           input logic [arpc_pkg::IP_W-1:0] ip,
                                           input logic [arpc_pkg::MAC_W-1:0] mac);
    reply_t               r;
    int                   free_slot;
    logic [TIME_BITS-1:0] age;
    r = '0;
    free_slot = -1;
    case (c)
      arpc_pkg::CMD_LOOKUP: begin
        // later slots win, so a duplicate in a later slot shadows the earlier one
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && slot_ip[i] == ip) begin
            r.hit = 1'b1;
            r.found_mac = slot_mac[i];
          end
        end
      end
      arpc_pkg::CMD_INSERT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!slot_valid[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot >= 0) begin
          slot_valid[free_slot] = 1'b1;
          slot_ip[free_slot]    = ip;
          slot_mac[free_slot]   = mac;
          slot_stamp[free_slot] = now_q;
          r.stored = 1'b1;
        end
      end
      arpc_pkg::CMD_TICK: begin
        now_q = now_q + 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i]) begin
            age = now_q - slot_stamp[i];
            if (age > TIME_BITS'(timeout_q)) begin
              slot_valid[i] = 1'b0;
              if (r.expired_count < arpc_pkg::COUNT_MAX)
                r.expired_count = r.expired_count + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic dir_row_t cmd_row(input arpc_pkg::cmd_t c,
                                       input logic [arpc_pkg::IP_W-1:0] ip,
                                       input logic [arpc_pkg::MAC_W-1:0] mac);
    dir_row_t row;
    row = '0;
    row.cmd = c;
    row.ip  = ip;
    row.mac = mac;
    return row;
  endfunction

  function automatic dir_row_t typed_row(input arpc_pkg::cmd_t c,
                                         input logic [arpc_pkg::IP_W-1:0] ip,
                                         input logic [arpc_pkg::MAC_W-1:0] mac,
                                         input logic hit,
                                         input logic [arpc_pkg::MAC_W-1:0] found,
                                         input logic stored,
                                         input logic [arpc_pkg::CNT_W-1:0] expired);
    dir_row_t row;
    row = cmd_row(c, ip, mac);
    row.typed = 1'b1;
    row.want  = '{hit, found, stored, expired};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [arpc_pkg::CFG_W-1:0] val);
    dir_row_t row;
    row = '0;
    row.is_cfg  = 1'b1;
    row.cfg_val = val;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_reply();
    reply_t want;
    if (pending_replies.size() == 0) begin
      report_mismatch("result beat with nothing pending", 64'(out_found_mac), 64'd0);
    end else begin
      want = pending_replies.pop_front();
      if (out_hit !== want.hit) report_mismatch("hit", 64'(out_hit), 64'(want.hit));
      if (out_found_mac !== want.found_mac)
        report_mismatch("found_mac", 64'(out_found_mac), 64'(want.found_mac));
      if (out_stored !== want.stored)
        report_mismatch("stored", 64'(out_stored), 64'(want.stored));
      if (out_expired_count !== want.expired_count)
        report_mismatch("expired_count", 64'(out_expired_count), 64'(want.expired_count));
    end
  endtask

  // results are checked before the new beat is predicted; both never share an edge anyway
  always @(posedge clk) begin
    reply_t r;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
      now_q     = '0;
      timeout_q = arpc_pkg::TIMEOUT_RESET;
    end else begin
      if (out_valid === 1'b1) check_reply();
      if (cfg_wr_en) timeout_q = cfg_wr_data;
      if (start && busy === 1'b0) begin
        r = predict_reply(arpc_pkg::cmd_t'(in_command), in_ip_addr, in_mac_addr);
        if (cur_typed) r = cur_want;
        pending_replies.push_back(r);
      end
    end
  end

  // watchdog: ends the run after too many cycles with no beat moving either way
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || out_valid === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // called at a falling edge, returns at one with nothing in flight and busy low
  task automatic wait_idle();
    start = 1'b0;
    while (pending_replies.size() != 0 || busy !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_timeout(input logic [arpc_pkg::CFG_W-1:0] val);
    wait_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // one command beat, sent in bursts with random gaps; start stays up while busy
  task automatic issue(input arpc_pkg::cmd_t c, input logic [arpc_pkg::IP_W-1:0] ip,
                       input logic [arpc_pkg::MAC_W-1:0] mac,
                       input logic typed, input reply_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_command  = c;
    in_ip_addr  = ip;
    in_mac_addr = mac;
    cur_typed   = typed;
    cur_want    = want;
    start       = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  initial begin
    dir_row_t                   dir_table [NUM_DIR];
    logic [arpc_pkg::IP_W-1:0]  ip_pool [POOL_SIZE];
    logic [arpc_pkg::IP_W-1:0]  ip;
    logic [arpc_pkg::MAC_W-1:0] mac;
    logic [arpc_pkg::CFG_W-1:0] tmo;
    arpc_pkg::cmd_t             c;
    int                         sent, phase, mode, n_items, r, ins_cut, look_cut;

    dir_table = '{
      // empty table after reset: every lookup misses, a tick expires nothing
      typed_row(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0, 1'b0, 48'h0, 1'b0, 7'd0),
      typed_row(arpc_pkg::CMD_LOOKUP, 32'hffff_ffff, 48'hffff_ffff_ffff,
                1'b0, 48'h0, 1'b0, 7'd0),
      // the unused command answers all zero
      typed_row(arpc_pkg::CMD_NONE, 32'hffff_ffff, 48'hffff_ffff_ffff,
                1'b0, 48'h0, 1'b0, 7'd0),
      typed_row(arpc_pkg::CMD_TICK, 32'h0, 48'h0, 1'b0, 48'h0, 1'b0, 7'd0),
      typed_row(arpc_pkg::CMD_INSERT, 32'h0, 48'h0, 1'b0, 48'h0, 1'b1, 7'd0),
      typed_row(arpc_pkg::CMD_INSERT, 32'hffff_ffff, 48'hffff_ffff_ffff,
                1'b0, 48'h0, 1'b1, 7'd0),
      // duplicate ip, the later slot must win on lookup
      cmd_row(arpc_pkg::CMD_INSERT, 32'h0, 48'h0123_4567_89ab),
      cmd_row(arpc_pkg::CMD_LOOKUP, 32'h0, 48'hffff_ffff_ffff),
      typed_row(arpc_pkg::CMD_LOOKUP, 32'hffff_ffff, 48'h0,
                1'b1, 48'hffff_ffff_ffff, 1'b0, 7'd0),
      typed_row(arpc_pkg::CMD_NONE, 32'h0, 48'h0, 1'b0, 48'h0, 1'b0, 7'd0),
      cmd_row(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0),
      cmd_row(arpc_pkg::CMD_LOOKUP, 32'h1234_5678, 48'h0),
      // zero timeout: everything expires on the next tick
      cfg_row(8'd0),
      cmd_row(arpc_pkg::CMD_TICK, 32'h0, 48'h0),
      typed_row(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0, 1'b0, 48'h0, 1'b0, 7'd0),
      cmd_row(arpc_pkg::CMD_INSERT, 32'hc0a8_0001, 48'h0011_2233_4455),
      cmd_row(arpc_pkg::CMD_TICK, 32'h0, 48'h0),
      cfg_row(8'd255),
      cmd_row(arpc_pkg::CMD_INSERT, 32'h0a00_0001, 48'haaaa_aaaa_aaaa),
      cmd_row(arpc_pkg::CMD_INSERT, 32'h0a00_0002, 48'h5555_5555_5555),
      cmd_row(arpc_pkg::CMD_TICK, 32'h0, 48'h0),
      cmd_row(arpc_pkg::CMD_LOOKUP, 32'h0a00_0001, 48'h0),
      cmd_row(arpc_pkg::CMD_LOOKUP, 32'h0a00_0002, 48'h0),
      cfg_row(8'd1),
      cmd_row(arpc_pkg::CMD_TICK, 32'h0, 48'h0),
      cmd_row(arpc_pkg::CMD_LOOKUP, 32'h0a00_0001, 48'h0)
    };

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed part, start is held until the clearing pass lets the first beat in
    for (int k = 0; k < NUM_DIR; k++) begin
      if (dir_table[k].is_cfg) begin
        write_timeout(dir_table[k].cfg_val);
      end else begin
        issue(dir_table[k].cmd, dir_table[k].ip, dir_table[k].mac, dir_table[k].typed,
              dir_table[k].want);
      end
    end

    // random phases: the first fills the table under the longest timeout, the
    // second ages it all out under a zero timeout, the rest are mixed
    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      if (phase == 0) begin
        tmo  = 8'd255;
        mode = 0;
      end else if (phase == 1) begin
        tmo  = 8'd0;
        mode = 2;
      end else begin
        case ($urandom_range(0, 4))
          0: tmo = 8'd0;
          1: tmo = 8'd255;
          2: tmo = 8'd1;
          default: tmo = arpc_pkg::CFG_W'($urandom_range(2, 40));
        endcase
        mode = $urandom_range(0, 2);
      end
      case (mode)
        0: begin
          ins_cut  = 73;
          look_cut = 93;
        end
        1: begin
          ins_cut  = 38;
          look_cut = 78;
        end
        default: begin
          ins_cut  = 28;
          look_cut = 58;
        end
      endcase
      write_timeout(tmo);

      // small address pool so lookups hit and duplicates pile up
      for (int k = 0; k < POOL_SIZE; k++) ip_pool[k] = $urandom;
      if ($urandom_range(0, 1) == 0) ip_pool[0] = 32'h0;
      if ($urandom_range(0, 1) == 0) ip_pool[1] = 32'hffff_ffff;

      n_items = (phase == 0) ? 120 : $urandom_range(40, 130);
      for (int j = 0; j < n_items && sent < RAND_ITEMS; j++) begin
        r = $urandom_range(0, 99);
        if (r < 3) c = arpc_pkg::CMD_NONE;
        else if (r < ins_cut) c = arpc_pkg::CMD_INSERT;
        else if (r < look_cut) c = arpc_pkg::CMD_LOOKUP;
        else c = arpc_pkg::CMD_TICK;

        ip = ($urandom_range(0, 99) < 80) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
        case ($urandom_range(0, 15))
          0: mac = '0;
          1: mac = '1;
          default: mac = arpc_pkg::MAC_W'({$urandom, $urandom});
        endcase

        // now and then let every result come home before going on
        if ($urandom_range(0, 29) == 0) wait_idle();
        issue(c, ip, mac, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    start = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0)
      report_mismatch("results never delivered", 64'(pending_replies.size()), 64'd0);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_ram.sv
hw/rtl/arpc_eval.sv
hw/rtl/arp_cache_table_with_ageing_unit.sv
sim/tb.sv
